@@ hw/rtl/ksmp_pkg.sv @@
`default_nettype none

package ksmp_pkg;

    localparam int MAX_KEYS  = 64;
    localparam int ADDR_W    = $clog2(MAX_KEYS);
    localparam int CNT_W     = $clog2(MAX_KEYS + 1);
    localparam int DATA_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int LP_W      = FRAC_W + 1;
    localparam int DIFF_W    = DATA_W + 1;
    localparam int PROD_W    = DIFF_W + LP_W + 1;
    localparam int CUR_OUT_W = 6;
    localparam int DIV_CNT_W = $clog2(FRAC_W);

    typedef logic [1:0]           t_op;
    typedef logic [ADDR_W-1:0]    t_addr;
    typedef logic [CNT_W-1:0]     t_count;
    typedef logic [LP_W-1:0]      t_lp;
    typedef logic [CUR_OUT_W-1:0] t_cur_out;
    typedef logic [DIV_CNT_W-1:0] t_div_cnt;

    localparam t_op OP_INSERT = 2'd0;
    localparam t_op OP_SAMPLE = 2'd1;
    localparam t_op OP_REWIND = 2'd2;

    localparam t_lp    LP_ONE   = {1'b1, {FRAC_W{1'b0}}};
    localparam t_count KEYS_MAX = t_count'(MAX_KEYS);

    // one stored key: three components and its time
    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
        logic        [DATA_W-1:0] ts;
    } t_key;

endpackage

`default_nettype wire

@@ hw/rtl/ksmp_ram.sv @@
`default_nettype none

module ksmp_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hw/rtl/ksmp_div.sv @@
`default_nettype none

// Restoring divider, one quotient bit per cycle: (num << FRAC_W) / den, num < den.
module ksmp_div (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_load,
    input  wire logic [ksmp_pkg::DATA_W-1:0]      i_num,
    input  wire logic [ksmp_pkg::DATA_W-1:0]      i_den,
    output logic                                  o_done,
    output logic      [ksmp_pkg::FRAC_W-1:0]      o_quot
);

    logic                            r_active;
    logic                            r_done;
    ksmp_pkg::t_div_cnt              r_cnt;
    logic [ksmp_pkg::DATA_W-1:0]     r_rem;
    logic [ksmp_pkg::DATA_W-1:0]     r_den;
    logic [ksmp_pkg::FRAC_W-1:0]     r_quot;

    logic [ksmp_pkg::DATA_W:0]       rem_sh;
    logic [ksmp_pkg::DATA_W+1:0]     sub;
    logic                            ge;

    always_comb begin
        rem_sh = {r_rem, 1'b0};
        sub    = {1'b0, rem_sh} - {2'b00, r_den};
        ge     = ~sub[ksmp_pkg::DATA_W+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_done   <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_load) begin
                r_active <= 1'b1;
                r_cnt    <= ksmp_pkg::t_div_cnt'(ksmp_pkg::FRAC_W - 1);
                r_rem    <= i_num;
                r_den    <= i_den;
                r_quot   <= '0;
            end else if (r_active) begin
                // remainder stays below den, so it fits DATA_W bits
                r_rem  <= ge ? sub[ksmp_pkg::DATA_W-1:0] : rem_sh[ksmp_pkg::DATA_W-1:0];
                r_quot <= {r_quot[ksmp_pkg::FRAC_W-2:0], ge};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_active <= 1'b0;
                    r_done   <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

@@ hw/rtl/ksmp_mac.sv @@
`default_nettype none

// a + floor((b - a) * lp / 2^FRAC_W), three register stages, one component per cycle.
module ksmp_mac (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    input  wire logic signed [ksmp_pkg::DATA_W-1:0] i_a,
    input  wire logic signed [ksmp_pkg::DATA_W-1:0] i_b,
    input  wire ksmp_pkg::t_lp                      i_lp,
    output logic                                    o_valid,
    output logic signed      [ksmp_pkg::DATA_W-1:0] o_res
);

    logic                                 r_v1, r_v2, r_v3;
    logic signed [ksmp_pkg::DIFF_W-1:0]   r_diff;
    logic signed [ksmp_pkg::DATA_W-1:0]   r_a1, r_a2;
    ksmp_pkg::t_lp                        r_lp1;
    logic signed [ksmp_pkg::PROD_W-1:0]   r_prod;
    logic signed [ksmp_pkg::DATA_W-1:0]   r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        r_diff <= {i_b[ksmp_pkg::DATA_W-1], i_b} - {i_a[ksmp_pkg::DATA_W-1], i_a};
        r_a1   <= i_a;
        r_lp1  <= i_lp;
        r_prod <= r_diff * $signed({1'b0, r_lp1});
        r_a2   <= r_a1;
        // arithmetic shift of the product gives the floor
        r_res  <= r_a2 + r_prod[ksmp_pkg::FRAC_W+ksmp_pkg::DATA_W-1:ksmp_pkg::FRAC_W];
    end

    assign o_valid = r_v3;
    assign o_res   = r_res;

endmodule

`default_nettype wire

@@ hw/rtl/keyframe_track_lerp_sampler_core.sv @@
`default_nettype none

// Keyframe track with linear-interpolation sampler, Q16.16 fixed point.
// Command channel: an op is taken at a clock edge with start high and busy low.
//   insert appends key (x, y, z, time_stamp); when the store is full the key
//   is dropped and o_store_full is set. sample interpolates between the cursor
//   key and the next at time_stamp and steps the cursor once time_stamp
//   reaches the next key's time. rewind puts the cursor back on the first key.
// Result channel: every op gives one result, shown for one cycle with o_done.
//   The receiver cannot stall; o_cursor_index is the cursor after the op.
// Ops: insert, rewind, unused op and a refused sample give their result in
//   the cycle after they are taken. A sample makes 2 key reads from the
//   single-read-port store, runs a bit-serial divider unless the factor is
//   exactly 0 or 1, then feeds one shared 3-stage multiply-add with x, y
//   and z in turn.
// busy is low whenever the result strobe is up, so the next op can be taken
// in that same cycle. A new op is taken only once the last has given its result.
// Reset (synchronous, active low) empties the track and zeroes the cursor;
// the key store itself is not cleared, entries past the key count are never
// used.
module keyframe_track_lerp_sampler_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire ksmp_pkg::t_op                      i_op,
    input  wire logic signed [ksmp_pkg::DATA_W-1:0] i_key_x,
    input  wire logic signed [ksmp_pkg::DATA_W-1:0] i_key_y,
    input  wire logic signed [ksmp_pkg::DATA_W-1:0] i_key_z,
    input  wire logic        [ksmp_pkg::DATA_W-1:0] i_time_stamp,
    output logic                                    o_done,
    output logic                                    o_updated,
    output logic signed      [ksmp_pkg::DATA_W-1:0] o_out_x,
    output logic signed      [ksmp_pkg::DATA_W-1:0] o_out_y,
    output logic signed      [ksmp_pkg::DATA_W-1:0] o_out_z,
    output ksmp_pkg::t_cur_out                      o_cursor_index,
    output logic                                    o_store_full
);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD1   = 3'd1;  // cursor key on read port
    localparam logic [2:0] S_WAIT  = 3'd2;  // next key on read port
    localparam logic [2:0] S_ABS   = 3'd3;  // special cases, magnitudes
    localparam logic [2:0] S_CMP   = 3'd4;  // num >= den clamps to one
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_MUL   = 3'd6;  // feed x, y, z to the multiply-add
    localparam logic [2:0] S_DRAIN = 3'd7;

    logic [2:0]                            r_state;
    ksmp_pkg::t_count                      r_key_count;
    ksmp_pkg::t_addr                       r_cursor;
    logic [ksmp_pkg::DATA_W-1:0]           r_t;
    ksmp_pkg::t_key                        r_a, r_b;
    logic signed [ksmp_pkg::DIFF_W-1:0]    r_num, r_den;
    logic                                  r_adv;
    ksmp_pkg::t_lp                         r_lp;
    logic [1:0]                            r_feed, r_got;
    logic                                  r_done, r_updated, r_full;
    logic signed [ksmp_pkg::DATA_W-1:0]    r_out_x, r_out_y, r_out_z;

    logic                                  accept;
    logic                                  can_sample;
    logic                                  wr_en;
    ksmp_pkg::t_key                        wr_key;
    ksmp_pkg::t_key                        rd_key;
    ksmp_pkg::t_addr                       rd_addr;
    logic                                  div_load, div_done;
    logic [ksmp_pkg::FRAC_W-1:0]           div_quot;
    logic                                  mac_in_valid, mac_valid;
    logic signed [ksmp_pkg::DATA_W-1:0]    mac_a, mac_b, mac_res;

    assign accept     = start && (r_state == S_IDLE);
    assign can_sample = (r_key_count >= ksmp_pkg::t_count'(2))
                     && ((ksmp_pkg::t_count'(r_cursor) + 1'b1) < r_key_count);
    assign wr_en      = accept && (i_op == ksmp_pkg::OP_INSERT)
                     && (r_key_count < ksmp_pkg::KEYS_MAX);

    always_comb begin
        wr_key.x  = i_key_x;
        wr_key.y  = i_key_y;
        wr_key.z  = i_key_z;
        wr_key.ts = i_time_stamp;
    end

    // idle: address the cursor key so its row is ready in S_RD1
    assign rd_addr = (r_state == S_IDLE) ? r_cursor : r_cursor + 1'b1;

    ksmp_ram #(
        .WIDTH ($bits(ksmp_pkg::t_key)),
        .DEPTH (ksmp_pkg::MAX_KEYS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_key_count[ksmp_pkg::ADDR_W-1:0]),
        .i_wdata (wr_key),
        .i_raddr (rd_addr),
        .o_rdata (rd_key)
    );

    assign div_load = (r_state == S_CMP) && (r_num < r_den);

    ksmp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (div_load),
        .i_num   (r_num[ksmp_pkg::DATA_W-1:0]),
        .i_den   (r_den[ksmp_pkg::DATA_W-1:0]),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign mac_in_valid = (r_state == S_MUL);

    always_comb begin
        case (r_feed)
            2'd0: begin
                mac_a = r_a.x;
                mac_b = r_b.x;
            end
            2'd1: begin
                mac_a = r_a.y;
                mac_b = r_b.y;
            end
            default: begin
                mac_a = r_a.z;
                mac_b = r_b.z;
            end
        endcase
    end

    ksmp_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mac_in_valid),
        .i_a     (mac_a),
        .i_b     (mac_b),
        .i_lp    (r_lp),
        .o_valid (mac_valid),
        .o_res   (mac_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_key_count <= '0;
            r_cursor    <= '0;
            r_feed      <= '0;
            r_got       <= '0;
            r_done      <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_t       <= i_time_stamp;
                        r_updated <= 1'b0;
                        r_full    <= 1'b0;
                        r_out_x   <= '0;
                        r_out_y   <= '0;
                        r_out_z   <= '0;
                        unique case (i_op)
                            ksmp_pkg::OP_INSERT: begin
                                r_done <= 1'b1;
                                if (r_key_count < ksmp_pkg::KEYS_MAX) begin
                                    r_key_count <= r_key_count + 1'b1;
                                end else begin
                                    r_full <= 1'b1;
                                end
                            end
                            ksmp_pkg::OP_SAMPLE: begin
                                if (can_sample) begin
                                    r_state <= S_RD1;
                                end else begin
                                    r_done <= 1'b1;
                                end
                            end
                            ksmp_pkg::OP_REWIND: begin
                                r_cursor <= '0;
                                r_done   <= 1'b1;
                            end
                            default: begin
                                r_done <= 1'b1;
                            end
                        endcase
                    end
                end
                S_RD1: begin
                    r_a     <= rd_key;
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    r_b     <= rd_key;
                    r_num   <= {1'b0, r_t} - {1'b0, r_a.ts};
                    r_den   <= {1'b0, rd_key.ts} - {1'b0, r_a.ts};
                    r_adv   <= (r_t >= rd_key.ts);
                    r_state <= S_ABS;
                end
                S_ABS: begin
                    if (r_den == '0) begin
                        // equal key times
                        r_lp    <= ksmp_pkg::LP_ONE;
                        r_state <= S_MUL;
                    end else if ((r_num == '0)
                              || (r_num[ksmp_pkg::DIFF_W-1] != r_den[ksmp_pkg::DIFF_W-1])) begin
                        // zero or negative quotient clamps to zero
                        r_lp    <= '0;
                        r_state <= S_MUL;
                    end else begin
                        if (r_num[ksmp_pkg::DIFF_W-1]) begin
                            r_num <= -r_num;
                            r_den <= -r_den;
                        end
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (r_num >= r_den) begin
                        r_lp    <= ksmp_pkg::LP_ONE;
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_lp    <= {1'b0, div_quot};
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (r_feed == 2'd2) begin
                        r_feed  <= '0;
                        r_state <= S_DRAIN;
                    end else begin
                        r_feed <= r_feed + 1'b1;
                    end
                end
                S_DRAIN: begin
                    // results collected below
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // results return in order x, y, z
            if (mac_valid) begin
                case (r_got)
                    2'd0: begin
                        r_out_x <= mac_res;
                        r_got   <= 2'd1;
                    end
                    2'd1: begin
                        r_out_y <= mac_res;
                        r_got   <= 2'd2;
                    end
                    default: begin
                        r_out_z   <= mac_res;
                        r_got     <= '0;
                        r_updated <= 1'b1;
                        r_done    <= 1'b1;
                        r_state   <= S_IDLE;
                        if (r_adv) begin
                            r_cursor <= r_cursor + 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_updated      = r_updated;
    assign o_out_x        = r_out_x;
    assign o_out_y        = r_out_y;
    assign o_out_z        = r_out_z;
    assign o_cursor_index = ksmp_pkg::t_cur_out'(r_cursor);
    assign o_store_full   = r_full;

endmodule

`default_nettype wire
